// ===== rtl/bbr_pkg.sv =====
// Shared types, constants and helpers for the bitstream byte buffer reader.
// No dependencies; bbr_extract and the top level import this package.
`default_nettype none

package bbr_pkg;

  // Field widths of the stream words
  localparam int OP_W     = 3;
  localparam int BYTE_W   = 8;
  localparam int AMT_W    = 13;
  localparam int VALUE_W  = 16;
  localparam int REM_W    = 16;
  localparam int IN_W     = 24;  // op + data_byte + amount, already whole bytes
  localparam int OUT_W    = 48;  // 46 bits of fields, padded to six bytes

  localparam int DEFAULT_STORE_DEPTH = 4096;
  localparam int MAX_READ_BITS       = 16;
  localparam int CNT_W               = 5;   // holds 0..MAX_READ_BITS

  typedef enum logic [OP_W-1:0] {
    OP_APPEND   = 3'd0,
    OP_READ_MSB = 3'd1,
    OP_READ_LSB = 3'd2,
    OP_ALIGN    = 3'd3,
    OP_SKIP     = 3'd4,
    OP_TRIM     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_DONE
  } state_t;

  // Control for the bit extractor
  typedef struct packed {
    logic             lsb_first;
    logic [2:0]       bit_pos;
    logic [CNT_W-1:0] count;
  } ext_ctrl_t;

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bbr_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
`default_nettype none

module bbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bbr_extract.sv =====
// Bit extractor: picks up to 16 bits out of a three-byte window.
// Depends on bbr_pkg (ext_ctrl_t, rev8).
`default_nettype none

module bbr_extract
  import bbr_pkg::*;
(
  input  wire logic [7:0]         byte0,
  input  wire logic [7:0]         byte1,
  input  wire logic [7:0]         byte2,
  input  wire ext_ctrl_t          ctrl,
  output logic      [VALUE_W-1:0] value
);

  logic [23:0]        window;
  logic [23:0]        shifted;
  logic [VALUE_W-1:0] top;
  logic [CNT_W-1:0]   rshift;

  // LSB-first order is MSB-first order on bit-reversed bytes
  always_comb begin
    if (ctrl.lsb_first) begin
      window = {rev8(byte0), rev8(byte1), rev8(byte2)};
    end else begin
      window = {byte0, byte1, byte2};
    end
    shifted = window << ctrl.bit_pos;
    top     = shifted[23:8];
    rshift  = CNT_W'(MAX_READ_BITS) - ctrl.count;
    if (ctrl.count == '0) begin
      value = '0;
    end else begin
      value = top >> rshift;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bitstream_byte_buffer_reader.sv =====
// Top level of the bitstream byte buffer reader: sequencer, cursor state,
// output register. Depends on bbr_pkg, bbr_ram, bbr_extract.
`default_nettype none

// Channel  Dir  Payload word (low bit first)                      Handshake
// s_axis   in   op[2:0] data_byte[10:3] amount[23:11]             tvalid/tready
// m_axis   out  value[15:0] old_position[28:16]                   tvalid/tready
//               remaining_bits[44:29] status[45] zero[47:46]
//
// Sequence: a read word goes from IDLE through RD1 and RD2 to DONE, with one
// memory read per byte of the three-byte window (single RAM port); its result
// is registered at the DONE commit. Every other op goes from IDLE straight to
// DONE. Output slot waits hold DONE for both.
// One word in flight; the next word is taken once the result sits in the
// output register, even if the sink has not taken it.
// Reset (rst, sync) empties the store: fill and cursor go to zero. The byte
// store itself is not cleared; the window may read past the fill, but only bits below it reach a value.
// A stalled sink holds the finished word in the done state; nothing updates
// until the output register frees up.

module bitstream_byte_buffer_reader
  import bbr_pkg::*;
#(
  parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,   // op, data_byte, amount
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [OUT_W-1:0] m_axis_tdata    // value, old_position, remaining_bits, status
);

  localparam int AW = $clog2(STORE_DEPTH);        // store address
  localparam int CW = $clog2(STORE_DEPTH + 1);    // fill and byte cursor
  localparam int PW = CW + 3;                     // bit position
  localparam int SW = ((CW > AMT_W) ? CW : AMT_W) + 1;

  // Bits between cursor and fill, zero when the cursor is past the fill
  function automatic logic [PW-1:0] bits_left(input logic [CW-1:0] f,
                                              input logic [CW-1:0] c,
                                              input logic [2:0]    b);
    logic [PW-1:0] total;
    logic [PW-1:0] used;
    total = {f, 3'b000};
    used  = {c, b};
    return (used >= total) ? '0 : (total - used);
  endfunction

  // ---- state ----
  state_t            state, state_next;
  logic [CW-1:0]     fill, fill_next;
  logic [CW-1:0]     cursor, cursor_next;
  logic [2:0]        bit_pos, bit_next;

  // accepted word
  op_t               op_q;
  logic [BYTE_W-1:0] byte_q;
  logic [AMT_W-1:0]  amount_q;

  // window bytes captured from the RAM
  logic [7:0]        b0, b1;

  // output register
  logic              out_valid;
  logic [OUT_W-1:0]  out_data;

  // ---- RAM port ----
  logic              ram_en, ram_we;
  logic [AW-1:0]     ram_addr;
  logic [7:0]        ram_wdata, ram_rdata;

  bbr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // ---- input decode ----
  op_t  op_in;
  logic accept;
  logic op_in_is_read;
  logic commit;

  assign op_in         = op_t'(s_axis_tdata[OP_W-1:0]);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op_in_is_read = (op_in == OP_READ_MSB) || (op_in == OP_READ_LSB);
  assign commit        = (state == S_DONE) && (!out_valid || m_axis_tready);

  // ---- extractor; third byte comes straight off the RAM ----
  ext_ctrl_t          ext_ctrl;
  logic [VALUE_W-1:0] ext_value;

  assign ext_ctrl.lsb_first = (op_q == OP_READ_LSB);
  assign ext_ctrl.bit_pos   = bit_pos;
  assign ext_ctrl.count     = amount_q[CNT_W-1:0];

  bbr_extract u_extract (
    .byte0 (b0),
    .byte1 (b1),
    .byte2 (ram_rdata),
    .ctrl  (ext_ctrl),
    .value (ext_value)
  );

  // ---- operation datapath, evaluated in S_DONE ----
  logic               status;
  logic [AMT_W-1:0]   old_pos;
  logic               rd_ok;
  logic               wr_store;
  logic [PW-1:0]      left_now;
  logic [PW-1:0]      left_after;
  logic [PW-1:0]      rd_pos;
  logic [SW-1:0]      skip_sum;
  logic [VALUE_W-1:0] value;

  always_comb begin
    fill_next   = fill;
    cursor_next = cursor;
    bit_next    = bit_pos;
    status      = 1'b0;
    old_pos     = '0;
    rd_ok       = 1'b0;
    wr_store    = 1'b0;
    left_now    = bits_left(fill, cursor, bit_pos);
    rd_pos      = {cursor, bit_pos} + PW'(amount_q[CNT_W-1:0]);
    skip_sum    = SW'(cursor) + SW'(amount_q);
    unique case (op_q)
      OP_APPEND: begin
        if (fill == CW'(STORE_DEPTH)) begin
          status = 1'b1;
        end else begin
          wr_store  = 1'b1;
          fill_next = fill + CW'(1);
        end
      end
      OP_READ_MSB, OP_READ_LSB: begin
        if (amount_q > AMT_W'(MAX_READ_BITS) ||
            PW'(amount_q[CNT_W-1:0]) > left_now) begin
          status = 1'b1;
        end else begin
          rd_ok                 = 1'b1;
          {cursor_next, bit_next} = rd_pos;
        end
      end
      OP_ALIGN: begin
        if (bit_pos != 3'd0) begin
          bit_next    = 3'd0;
          cursor_next = cursor + CW'(1);
        end
      end
      OP_SKIP: begin
        old_pos = AMT_W'(cursor);
        if (skip_sum > SW'(fill)) begin
          status = 1'b1;
        end else begin
          cursor_next = CW'(skip_sum);
        end
      end
      OP_TRIM: begin
        // zero count or count covering the whole fill clears everything
        if (amount_q != '0 && SW'(fill) > SW'(amount_q)) begin
          fill_next = CW'(SW'(fill) - SW'(amount_q));
        end else begin
          fill_next   = '0;
          cursor_next = '0;
          bit_next    = 3'd0;
        end
      end
      default: begin
        status = 1'b1;
      end
    endcase
    left_after = bits_left(fill_next, cursor_next, bit_next);
    value      = rd_ok ? ext_value : '0;
  end

  // ---- sequencer: next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = op_in_is_read ? S_RD1 : S_DONE;
        end
      end
      S_RD1:  state_next = S_RD2;
      S_RD2:  state_next = S_DONE;
      S_DONE: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---- sequencer: outputs (RAM port, input ready) ----
  // Append writes only at commit; reads are issued after that, so the single
  // port never sees a write and a read to the same byte overlap.
  always_comb begin
    s_axis_tready = 1'b0;
    ram_en        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = AW'(cursor);
    ram_wdata     = byte_q;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        ram_en        = s_axis_tvalid && op_in_is_read;
      end
      S_RD1: begin
        ram_en   = 1'b1;
        ram_addr = AW'(cursor) + AW'(1);
      end
      S_RD2: begin
        ram_en   = 1'b1;
        ram_addr = AW'(cursor) + AW'(2);
      end
      S_DONE: begin
        ram_en   = commit && wr_store;
        ram_we   = 1'b1;
        ram_addr = AW'(fill);
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      cursor    <= '0;
      bit_pos   <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        fill      <= fill_next;
        cursor    <= cursor_next;
        bit_pos   <= bit_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= op_in;
      byte_q   <= s_axis_tdata[OP_W +: BYTE_W];
      amount_q <= s_axis_tdata[OP_W + BYTE_W +: AMT_W];
    end
    if (state == S_RD1) begin
      b0 <= ram_rdata;
    end
    if (state == S_RD2) begin
      b1 <= ram_rdata;
    end
    if (commit) begin
      out_data <= {2'b00, status, REM_W'(left_after), old_pos, value};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

`ifndef SYNTHESIS
  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(STORE_DEPTH))
    else $error("fill count exceeds store depth");

  a_cursor_bound : assert property (@(posedge clk) disable iff (rst)
    cursor <= CW'(STORE_DEPTH))
    else $error("byte cursor exceeds store depth");

  a_append_fill : assert property (@(posedge clk) disable iff (rst)
    commit && op_q == OP_APPEND |=>
      fill == $past(fill) + CW'(1) || $past(fill) == CW'(STORE_DEPTH))
    else $error("append did not advance the fill");

  a_read_seq : assert property (@(posedge clk) disable iff (rst)
    accept && op_in_is_read |=> state == S_RD1 ##1 state == S_RD2 ##1 state == S_DONE)
    else $error("read sequence skipped a window byte");
`endif

endmodule

`default_nettype wire
